/* hw/rtl/itrs_pkg.sv */
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types, constants and helpers of the integer to radix string core.
// ----------------------------------------------------------------------------
package itrs_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int MAX_DIGITS_DEF = 32;
    localparam int RADIX_WIDTH    = 6;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] DIGIT_MAX_NUM = 6'd9;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [RADIX_WIDTH-1:0]        radix;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out;

    // One classified conversion waiting for the digit engine.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] magnitude;
        logic                   negative;
        logic [RADIX_WIDTH-1:0] radix;
    } t_job;

    function automatic logic [7:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
        logic [7:0] ext;
        ext = {2'b00, d};
        if (d > DIGIT_MAX_NUM) begin
            return CH_A + ext - {2'b00, RADIX_DEC};
        end
        return CH_ZERO + ext;
    endfunction

endpackage

/* hw/rtl/itrs_ram.sv */
// ----------------------------------------------------------------------------
// itrs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module itrs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/itrs_front.sv */
// ----------------------------------------------------------------------------
// itrs_front
// Accepts input words, saturates the radix, splits sign and magnitude, and
// holds the classified jobs in a two-entry queue for the digit engine.
// ----------------------------------------------------------------------------
module itrs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  itrs_pkg::t_in i_in,
    input  logic          i_pop,
    output logic          o_job_valid,
    output itrs_pkg::t_job o_job
);

    localparam int W = itrs_pkg::VALUE_WIDTH;

    itrs_pkg::t_job r_q [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;

    itrs_pkg::t_job job_in;
    logic [itrs_pkg::RADIX_WIDTH-1:0] radix_sat;
    logic push;
    logic pop;

    always_comb begin
        radix_sat = i_in.radix;
        if (i_in.radix < itrs_pkg::RADIX_MIN) begin
            radix_sat = itrs_pkg::RADIX_MIN;
        end else if (i_in.radix > itrs_pkg::RADIX_MAX) begin
            radix_sat = itrs_pkg::RADIX_MAX;
        end
        job_in.radix    = radix_sat;
        // Only radix ten reads the value as signed.
        job_in.negative = (radix_sat == itrs_pkg::RADIX_DEC) && i_in.value[W-1];
        job_in.magnitude = job_in.negative ? (W'(0) - W'(i_in.value)) : W'(i_in.value);
    end

    assign busy        = (r_count == 2'd2);
    assign push        = start && !busy;
    assign pop         = i_pop && (r_count != 2'd0);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job_in;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_count != 2'd0))
        else $error("queue empty after an accepted word");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3) && ((r_count == 2'd1) || (r_wr_ptr == r_rd_ptr)))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

/* hw/rtl/itrs_back.sv */
// ----------------------------------------------------------------------------
// itrs_back
// Digit engine: divides the magnitude by the radix one quotient bit a cycle,
// stores the digits, then emits sign and digits most significant first.
// ----------------------------------------------------------------------------
module itrs_back #(
    parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  itrs_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_strobe,
    output itrs_pkg::t_out o_out
);

    localparam int W  = itrs_pkg::VALUE_WIDTH;
    localparam int RW = itrs_pkg::RADIX_WIDTH;
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int BW = $clog2(W);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_READ = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [W-1:0]    r_q, n_q;
    logic [RW-1:0]   r_p, n_p;
    logic [RW-1:0]   r_rad, n_rad;
    logic            r_neg, n_neg;
    logic [BW-1:0]   r_bit, n_bit;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_idx, n_idx;

    logic [RW:0]     p_sh;
    logic [RW:0]     p_diff;
    logic            ge;
    logic [RW-1:0]   p_step;
    logic [W-1:0]    q_step;
    logic [CW-1:0]   limit;
    logic            ram_we;
    logic [RW-1:0]   ram_rdata;

    // Restoring division step: shift one dividend bit into the remainder.
    always_comb begin
        p_sh   = {r_p, r_q[W-1]};
        p_diff = p_sh - {1'b0, r_rad};
        ge     = (p_sh >= {1'b0, r_rad});
        p_step = ge ? p_diff[RW-1:0] : p_sh[RW-1:0];
        q_step = {r_q[W-2:0], ge};
        limit  = r_neg ? CW'(MAX_DIGITS - 1) : CW'(MAX_DIGITS);
    end

    always_comb begin
        n_state  = r_state;
        n_q      = r_q;
        n_p      = r_p;
        n_rad    = r_rad;
        n_neg    = r_neg;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        o_pop    = 1'b0;
        ram_we   = 1'b0;
        o_strobe = 1'b0;
        o_out    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_q     = i_job.magnitude;
                    n_rad   = i_job.radix;
                    n_neg   = i_job.negative;
                    n_p     = '0;
                    n_bit   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_q   = q_step;
                n_p   = p_step;
                n_bit = r_bit + BW'(1);
                if (r_bit == BW'(W - 1)) begin
                    // Digit done: the remainder goes to the store.
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_p    = '0;
                    n_bit  = '0;
                    if ((q_step == '0) || (n_cnt == limit)) begin
                        n_idx   = r_cnt[AW-1:0];
                        n_state = r_neg ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN: begin
                o_strobe        = 1'b1;
                o_out.character = itrs_pkg::CH_MINUS;
                o_out.last      = 1'b0;
                n_state         = S_READ;
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_strobe        = 1'b1;
                o_out.character = itrs_pkg::digit_char(ram_rdata);
                o_out.last      = (r_idx == '0);
                if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q     <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_rad <= n_rad;
        r_idx <= n_idx;
    end

    itrs_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (p_step),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    a_strobe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((r_state == S_SIGN) || (r_state == S_EMIT)))
        else $error("character strobed outside an output state");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last) |=> !o_strobe)
        else $error("character strobed right after the last one");
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < limit))
        else $error("digit count reached the limit during division");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_DIV))
        else $error("job taken without starting division");
`endif

endmodule

/* hw/rtl/integer_to_radix_string_core.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_string_core
// Converts an integer into its ASCII digit string in radix 2 to 36.
//
// Channel   Direction  Handshake                 Payload
// input     in         start high, busy low      i_in  (value, radix)
// result    out        o_strobe for one cycle    o_out (character, last)
//
// Each digit passes through the shared restoring divider, one quotient
// bit a cycle. Each character is read from the registered digit RAM in
// S_READ and emitted in S_EMIT; a leading '-' is emitted from S_SIGN first.
// The front queue holds two words, so busy rises only with both slots full.
// Reset is synchronous and active low and empties the queue and the engine.
// The receiver cannot stall; every character is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module integer_to_radix_string_core #(
    parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  itrs_pkg::t_in  i_in,
    output logic           o_strobe,
    output itrs_pkg::t_out o_out
);

    logic           job_valid;
    logic           job_pop;
    itrs_pkg::t_job job;

    itrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .i_pop       (job_pop),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    itrs_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (job_pop),
        .o_strobe    (o_strobe),
        .o_out       (o_out)
    );

endmodule

/* tb/integer_to_radix_string_checker.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_string_checker
// Watches the input and result channels of the integer to radix string core.
// Every accepted input word is expanded into its expected character string.
// Each strobed result is compared with the oldest expected character.
// ----------------------------------------------------------------------------
module integer_to_radix_string_checker #(
    parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  itrs_pkg::t_in  i_in,
    input  logic           i_strobe,
    input  itrs_pkg::t_out i_out,
    output int             o_errors,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import itrs_pkg::*;

    localparam int MAX_REPORTS = 10;

    t_out expected_chars[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [7:0] ascii_digit(input logic [RADIX_WIDTH-1:0] d);
        if (d > DIGIT_MAX_NUM) begin
            return CH_A + 8'(d - RADIX_DEC);
        end
        return CH_ZERO + 8'(d);
    endfunction

    // Expands one input word into the characters that the core must emit.
    function automatic void queue_string(input t_in w);
        logic [RADIX_WIDTH-1:0] base;
        logic [VALUE_WIDTH-1:0] bits;
        logic [VALUE_WIDTH-1:0] mag;
        logic [RADIX_WIDTH-1:0] digits[MAX_DIGITS];
        logic                   negative;
        int                     count;
        int                     limit;
        t_out                   ch;

        base = w.radix;
        if (base < RADIX_MIN) begin
            base = RADIX_MIN;
        end
        if (base > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        bits     = w.value;
        negative = (base == RADIX_DEC) && bits[VALUE_WIDTH-1];
        mag      = negative ? (~bits + 1'b1) : bits;
        limit    = negative ? MAX_DIGITS - 1 : MAX_DIGITS;
        count    = 0;
        do begin
            digits[count] = RADIX_WIDTH'(mag % VALUE_WIDTH'(base));
            count++;
            mag = mag / VALUE_WIDTH'(base);
        end while (mag != 0 && count < limit);

        if (negative) begin
            ch.character = CH_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int k = count - 1; k >= 0; k--) begin
            ch.character = ascii_digit(digits[k]);
            ch.last      = (k == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic void report(input string what, input t_out exp_w, input t_out got);
        o_errors++;
        if (o_errors <= MAX_REPORTS) begin
            $display("%0t mismatch in %s: expected char %h last %b, got char %h last %b",
                     $realtime, what, exp_w.character, exp_w.last, got.character, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS) begin
                        $display("%0t unexpected word: char %h last %b", $realtime,
                                 i_out.character, i_out.last);
                    end
                end else begin
                    exp_w = expected_chars.pop_front();
                    if (i_out.character !== exp_w.character) begin
                        report("character", exp_w, i_out);
                    end else if (i_out.last !== exp_w.last) begin
                        report("last flag", exp_w, i_out);
                    end
                end
            end
            if (i_start && !i_busy) begin
                queue_string(i_in);
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

/* tb/integer_to_radix_string_core_tb.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_string_core_tb
// Drives the integer to radix string core with directed and random words.
// Directed words cover the extremes, every radix class and the signed cases;
// random words mix full-range, small and extreme values over all radix codes.
// ----------------------------------------------------------------------------
module integer_to_radix_string_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itrs_pkg::*;

    localparam int RANDOM_WORDS = 350;
    localparam int QUIET_TAIL   = 60;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [VALUE_WIDTH-1:0] INT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] INT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] ALL_ONES = {VALUE_WIDTH{1'b1}};

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_in;
    logic o_strobe;
    t_out o_out;
    int   errors;
    int   pending;
    int   idle_cycles;

    integer_to_radix_string_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    integer_to_radix_string_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_in      (i_in),
        .i_strobe  (o_strobe),
        .i_out     (o_out),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Presents one word and returns at the edge that accepts it; start stays high.
    task automatic send_word(input logic [VALUE_WIDTH-1:0] value,
                             input logic [RADIX_WIDTH-1:0] radix);
        @(negedge i_clk);
        start      <= 1'b1;
        i_in.value <= value;
        i_in.radix <= radix;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start      <= 1'b0;
        i_in.value <= $urandom;
        i_in.radix <= RADIX_WIDTH'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending == 0);
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return VALUE_WIDTH'($urandom_range(0, 40));
            1: return ~VALUE_WIDTH'($urandom_range(0, 40));
            2: begin
                case ($urandom_range(0, 3))
                    0: return INT_MIN;
                    1: return INT_MAX;
                    2: return ALL_ONES;
                    default: return '0;
                endcase
            end
            3: return VALUE_WIDTH'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RADIX_WIDTH-1:0] pick_radix();
        case ($urandom_range(0, 5))
            0: return RADIX_DEC;
            1: return RADIX_WIDTH'($urandom_range(0, 63));
            default: return RADIX_WIDTH'($urandom_range(RADIX_MIN, RADIX_MAX));
        endcase
    endfunction

    // Ends the run when neither channel moves for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        start   = 1'b0;
        i_in    = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero, signed extremes and unsigned readings of negative bits.
        send_word('0, RADIX_DEC);
        send_word('0, RADIX_MIN);
        send_word(ALL_ONES, RADIX_DEC);
        send_word(INT_MIN, RADIX_DEC);
        send_word(INT_MAX, RADIX_DEC);
        send_word(INT_MIN, RADIX_MIN);
        send_word(ALL_ONES, RADIX_MIN);
        send_word(ALL_ONES, RADIX_MAX);
        send_word(ALL_ONES, 6'd16);
        send_word(-VALUE_WIDTH'(123), RADIX_DEC);
        send_word(-VALUE_WIDTH'(5), 6'd16);
        // Highest digit of each letter boundary.
        send_word(VALUE_WIDTH'(35), RADIX_MAX);
        send_word(VALUE_WIDTH'(10), 6'd11);
        send_word(VALUE_WIDTH'(9), RADIX_DEC);
        send_word(VALUE_WIDTH'(255), 6'd16);
        send_word(VALUE_WIDTH'(123456789), RADIX_DEC);
        send_word(VALUE_WIDTH'(1), 6'd3);
        // Radix codes below and above the legal range saturate.
        send_word(VALUE_WIDTH'(6), 6'd0);
        send_word(VALUE_WIDTH'(6), 6'd1);
        send_word(VALUE_WIDTH'(71), 6'd37);
        send_word(ALL_ONES, 6'd63);
        send_word(INT_MIN, 6'd63);
        send_word('0, 6'd63);
        drain_all();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 3));
            end
            if (n == RANDOM_WORDS / 2) begin
                drain_all();
            end
            send_word(pick_value(), pick_radix());
        end
        drain_all();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/itrs_pkg.sv
hw/rtl/itrs_ram.sv
hw/rtl/itrs_front.sv
hw/rtl/itrs_back.sv
hw/rtl/integer_to_radix_string_core.sv
tb/integer_to_radix_string_checker.sv
tb/integer_to_radix_string_core_tb.sv
